### rtl/core/dro_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dro_pkg
// Shared constants, angle table and interface types of the odometry core.
// ----------------------------------------------------------------------------
package dro_pkg;

   localparam int CordicSteps = 16;
   localparam int StepW       = 5;
   localparam int XyW         = 40;
   localparam int AngW        = 36;
   localparam int MulW        = 32;

   localparam logic signed [AngW-1:0] AngPi     = 36'sd843314857;
   localparam logic signed [AngW-1:0] AngTwoPi  = 36'sd1686629714;
   localparam logic signed [AngW-1:0] AngHalfPi = 36'sd421657428;
   localparam logic signed [XyW-1:0]  CordicGain = 40'sd652032875;

   typedef struct packed {
      logic                  load;
      logic                  step;
      logic                  vectoring;
      logic signed [XyW-1:0]  x0;
      logic signed [XyW-1:0]  y0;
      logic signed [AngW-1:0] z0;
   } cordic_cmd_type;

   typedef struct packed {
      logic signed [XyW-1:0]  x;
      logic signed [XyW-1:0]  y;
      logic signed [AngW-1:0] z;
      logic                   last;
   } cordic_res_type;

   function automatic logic signed [AngW-1:0] atan_entry(input logic [StepW-1:0] k);
      logic signed [AngW-1:0] r;
      unique case (k)
         5'd0:  r = 36'sd210828714;
         5'd1:  r = 36'sd124459457;
         5'd2:  r = 36'sd65760959;
         5'd3:  r = 36'sd33381290;
         5'd4:  r = 36'sd16755422;
         5'd5:  r = 36'sd8385879;
         5'd6:  r = 36'sd4193963;
         5'd7:  r = 36'sd2097109;
         5'd8:  r = 36'sd1048571;
         5'd9:  r = 36'sd524287;
         5'd10: r = 36'sd262144;
         5'd11: r = 36'sd131072;
         5'd12: r = 36'sd65536;
         5'd13: r = 36'sd32768;
         5'd14: r = 36'sd16384;
         5'd15: r = 36'sd8192;
         5'd16: r = 36'sd4096;
         5'd17: r = 36'sd2048;
         5'd18: r = 36'sd1024;
         5'd19: r = 36'sd512;
         5'd20: r = 36'sd256;
         5'd21: r = 36'sd128;
         5'd22: r = 36'sd64;
         5'd23: r = 36'sd32;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/dead_reckoning_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dead_reckoning_odometry
// Wheel/IMU odometry: yaw by CORDIC atan2, midpoint position update,
// heading quaternion by CORDIC rotation, under one sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | wheel, rate, quaternion, dt
//  rsp     | out       | rsp_valid/rsp_ready | position, heading, speeds, orient
//
//  Each item runs two CORDIC rotations always, one atan2 vectoring with an
//  IMU sample and angle reduction steps before the next item is accepted.
//  The single CORDIC unit and the single multiplier serve all of them.
//  req_ready is high only while the sequencer is idle; the result register
//  frees it as soon as the item's result is loaded.
//  Synchronous reset clears pose, heading and the yaw reference.
// ----------------------------------------------------------------------------
module dead_reckoning_odometry (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_vel_valid,
   input  logic signed [15:0] req_wheel_a,
   input  logic signed [15:0] req_wheel_b,
   input  logic signed [15:0] req_yaw_rate,
   input  logic               req_imu_valid,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic        [15:0] req_elapsed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [15:0] rsp_heading_out,
   output logic signed [15:0] rsp_lin_vel,
   output logic signed [15:0] rsp_ang_vel,
   output logic signed [15:0] rsp_orient_z,
   output logic signed [15:0] rsp_orient_w
);

   typedef enum logic [4:0] {
      S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
      S_AT_PRE, S_AT_IT, S_YAW, S_P0, S_P1, S_P2,
      S_RED, S_FOLD, S_ROT_IT, S_ROT_DONE, S_X, S_Y, S_Y2, S_DONE
   } state_type;

   localparam int MW = dro_pkg::MulW;
   localparam int XW = dro_pkg::XyW;
   localparam int AW = dro_pkg::AngW;

   state_type state_ff;
   logic signed [15:0]   lin_ff, ang_ff, qw_ff, qx_ff, qy_ff, qz_ff;
   logic        [15:0]   dt_ff;
   logic signed [33:0]   num_ff, den_ff;
   logic signed [31:0]   acc_x_ff, acc_y_ff, prod_ff, c_ff, s_ff;
   logic signed [15:0]   heading_ff, rel_yaw_ff, ref_yaw_ff;
   logic                 latched_ff, neg_ff, phase_ff;
   logic signed [AW-1:0] ang_a_ff;
   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_pos_x_ff, rsp_pos_y_ff;
   logic signed [15:0]   rsp_heading_ff, rsp_lin_ff, rsp_ang_ff, rsp_oz_ff, rsp_ow_ff;

   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] mul_p;
   dro_pkg::cordic_cmd_type cmd;
   dro_pkg::cordic_res_type res;

   logic signed [16:0]   wheel_sum;
   logic signed [63:0]   rnd;
   logic signed [33:0]   acc_sum;
   logic signed [31:0]   acc_sat;
   logic signed [31:0]   acc_sel;
   logic signed [AW-1:0] yaw_rnd;
   logic signed [15:0]   yaw;
   logic signed [32:0]   oz_r, ow_r;
   logic signed [15:0]   oz_c, ow_c;
   logic signed [XW-1:0] c_full, s_full;

   dro_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   dro_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_M0:    begin mul_a = MW'(qx_ff); mul_b = MW'(qy_ff); end
         S_M1:    begin mul_a = MW'(qw_ff); mul_b = MW'(qz_ff); end
         S_M2:    begin mul_a = MW'(qw_ff); mul_b = MW'(qw_ff); end
         S_M3:    begin mul_a = MW'(qx_ff); mul_b = MW'(qx_ff); end
         S_M4:    begin mul_a = MW'(qy_ff); mul_b = MW'(qy_ff); end
         S_M5:    begin mul_a = MW'(qz_ff); mul_b = MW'(qz_ff); end
         S_P0:    begin mul_a = MW'(ang_ff); mul_b = MW'({1'b0, dt_ff}); end
         S_P1:    begin mul_a = MW'(lin_ff); mul_b = MW'({1'b0, dt_ff}); end
         S_X:     begin mul_a = prod_ff; mul_b = c_ff; end
         S_Y:     begin mul_a = prod_ff; mul_b = s_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_AT_PRE: begin
            cmd.load      = 1'b1;
            cmd.vectoring = 1'b1;
            if (den_ff < 0) begin
               cmd.x0 = -XW'(den_ff);
               cmd.y0 = -XW'(num_ff);
               cmd.z0 = (num_ff >= 0) ? dro_pkg::AngPi : -dro_pkg::AngPi;
            end else begin
               cmd.x0 = XW'(den_ff);
               cmd.y0 = XW'(num_ff);
               cmd.z0 = '0;
            end
         end
         S_FOLD: begin
            cmd.load = 1'b1;
            cmd.x0   = dro_pkg::CordicGain;
            cmd.y0   = '0;
            if (ang_a_ff > dro_pkg::AngHalfPi) begin
               cmd.z0 = ang_a_ff - dro_pkg::AngPi;
            end else if (ang_a_ff < -dro_pkg::AngHalfPi) begin
               cmd.z0 = ang_a_ff + dro_pkg::AngPi;
            end else begin
               cmd.z0 = ang_a_ff;
            end
         end
         S_AT_IT, S_ROT_IT: cmd.step = 1'b1;
         default: cmd = '0;
      endcase
   end

   assign wheel_sum = 17'(req_wheel_a) + 17'(req_wheel_b);
   assign rnd       = mul_p + 64'sh200_0000_0000;
   assign acc_sel   = (state_ff == S_Y) ? acc_x_ff : acc_y_ff;
   assign acc_sum   = 34'(acc_sel) + 34'(rnd >>> 42);
   assign acc_sat   = (acc_sum > 34'sh0_7FFF_FFFF)  ? 32'sh7FFF_FFFF :
                      (acc_sum < -34'sh0_8000_0000) ? 32'sh8000_0000 : acc_sum[31:0];
   assign yaw_rnd   = res.z + AW'(32768);
   assign yaw       = yaw_rnd[31:16];
   assign c_full    = neg_ff ? -res.x : res.x;
   assign s_full    = neg_ff ? -res.y : res.y;
   assign oz_r      = (33'(s_ff) + 33'sd32768) >>> 16;
   assign ow_r      = (33'(c_ff) + 33'sd32768) >>> 16;
   assign oz_c      = (oz_r > 33'sd16384) ? 16'sd16384 :
                      (oz_r < -33'sd16384) ? -16'sd16384 : oz_r[15:0];
   assign ow_c      = (ow_r > 33'sd16384) ? 16'sd16384 :
                      (ow_r < -33'sd16384) ? -16'sd16384 : ow_r[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         heading_ff   <= '0;
         rel_yaw_ff   <= '0;
         ref_yaw_ff   <= '0;
         latched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         if (rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  lin_ff   <= req_vel_valid ? wheel_sum[16:1] : '0;
                  ang_ff   <= req_vel_valid ? req_yaw_rate : '0;
                  dt_ff    <= req_elapsed;
                  qw_ff    <= req_quat_w;
                  qx_ff    <= req_quat_x;
                  qy_ff    <= req_quat_y;
                  qz_ff    <= req_quat_z;
                  state_ff <= req_imu_valid ? S_M0 : S_P0;
               end
            end
            S_M0: state_ff <= S_M1;
            S_M1: begin
               num_ff   <= mul_p[33:0];
               state_ff <= S_M2;
            end
            S_M2: begin
               num_ff   <= (num_ff + mul_p[33:0]) <<< 1;
               state_ff <= S_M3;
            end
            S_M3: begin
               den_ff   <= mul_p[33:0];
               state_ff <= S_M4;
            end
            S_M4: begin
               den_ff   <= den_ff + mul_p[33:0];
               state_ff <= S_M5;
            end
            S_M5: begin
               den_ff   <= den_ff - mul_p[33:0];
               state_ff <= S_M6;
            end
            S_M6: begin
               den_ff   <= den_ff - mul_p[33:0];
               state_ff <= S_AT_PRE;
            end
            S_AT_PRE: begin
               state_ff <= (num_ff == '0 && den_ff == '0) ? S_YAW : S_AT_IT;
            end
            S_AT_IT: begin
               if (res.last) begin
                  state_ff <= S_YAW;
               end
            end
            S_YAW: begin
               if (!latched_ff) begin
                  ref_yaw_ff <= yaw;
                  latched_ff <= 1'b1;
                  rel_yaw_ff <= '0;
               end else begin
                  rel_yaw_ff <= yaw - ref_yaw_ff;
               end
               state_ff <= S_P0;
            end
            S_P0: state_ff <= S_P1;
            S_P1: begin
               ang_a_ff <= {{(AW-32){heading_ff[15]}}, heading_ff, 16'b0}
                           + AW'(mul_p >>> 1);
               phase_ff <= 1'b0;
               state_ff <= S_P2;
            end
            S_P2: begin
               prod_ff  <= mul_p[31:0];
               state_ff <= S_RED;
            end
            S_RED: begin
               if (ang_a_ff > dro_pkg::AngPi) begin
                  ang_a_ff <= ang_a_ff - dro_pkg::AngTwoPi;
               end else if (ang_a_ff < -dro_pkg::AngPi) begin
                  ang_a_ff <= ang_a_ff + dro_pkg::AngTwoPi;
               end else begin
                  state_ff <= S_FOLD;
               end
            end
            S_FOLD: begin
               neg_ff   <= (ang_a_ff > dro_pkg::AngHalfPi) ||
                           (ang_a_ff < -dro_pkg::AngHalfPi);
               state_ff <= S_ROT_IT;
            end
            S_ROT_IT: begin
               if (res.last) begin
                  state_ff <= S_ROT_DONE;
               end
            end
            S_ROT_DONE: begin
               c_ff     <= c_full[31:0];
               s_ff     <= s_full[31:0];
               state_ff <= phase_ff ? S_DONE : S_X;
            end
            S_X: state_ff <= S_Y;
            S_Y: begin
               acc_x_ff <= acc_sat;
               state_ff <= S_Y2;
            end
            S_Y2: begin
               acc_y_ff   <= acc_sat;
               heading_ff <= rel_yaw_ff;
               ang_a_ff   <= {{(AW-31){rel_yaw_ff[15]}}, rel_yaw_ff, 15'b0};
               phase_ff   <= 1'b1;
               state_ff   <= S_RED;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_pos_x_ff   <= acc_x_ff;
                  rsp_pos_y_ff   <= acc_y_ff;
                  rsp_heading_ff <= heading_ff;
                  rsp_lin_ff     <= lin_ff;
                  rsp_ang_ff     <= ang_ff;
                  rsp_oz_ff      <= oz_c;
                  rsp_ow_ff      <= ow_c;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_pos_x_ff;
   assign rsp_pos_y       = rsp_pos_y_ff;
   assign rsp_heading_out = rsp_heading_ff;
   assign rsp_lin_vel     = rsp_lin_ff;
   assign rsp_ang_vel     = rsp_ang_ff;
   assign rsp_orient_z    = rsp_oz_ff;
   assign rsp_orient_w    = rsp_ow_ff;

endmodule

### rtl/core/dro_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dro_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dro_mul (
   input  logic                                clock,
   input  logic signed [dro_pkg::MulW-1:0]     op_a,
   input  logic signed [dro_pkg::MulW-1:0]     op_b,
   output logic signed [2*dro_pkg::MulW-1:0]   prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

### rtl/core/dro_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dro_cordic
// Iterative CORDIC, one micro-rotation per cycle while cmd.step is high, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module dro_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  dro_pkg::cordic_cmd_type cmd,
   output dro_pkg::cordic_res_type res
);

   logic signed [dro_pkg::XyW-1:0]  x_ff, y_ff, dx, dy;
   logic signed [dro_pkg::AngW-1:0] z_ff, at;
   logic [dro_pkg::StepW-1:0]       k_ff;
   logic                            vec_ff;

   assign dx = x_ff >>> k_ff;
   assign dy = y_ff >>> k_ff;
   assign at = dro_pkg::atan_entry(k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         vec_ff <= 1'b0;
      end else if (cmd.load) begin
         x_ff   <= cmd.x0;
         y_ff   <= cmd.y0;
         z_ff   <= cmd.z0;
         k_ff   <= '0;
         vec_ff <= cmd.vectoring;
      end else if (cmd.step) begin
         k_ff <= k_ff + 1'b1;
         if (vec_ff) begin
            if (y_ff > 0) begin
               x_ff <= x_ff + dy;
               y_ff <= y_ff - dx;
               z_ff <= z_ff + at;
            end else begin
               x_ff <= x_ff - dy;
               y_ff <= y_ff + dx;
               z_ff <= z_ff - at;
            end
         end else begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - dy;
               y_ff <= y_ff + dx;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dy;
               y_ff <= y_ff - dx;
               z_ff <= z_ff + at;
            end
         end
      end
   end

   assign res.x    = x_ff;
   assign res.y    = y_ff;
   assign res.z    = z_ff;
   assign res.last = (k_ff == dro_pkg::StepW'(dro_pkg::CordicSteps - 1));

endmodule
